FILE: hw/rtl/scalar_kalman_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Scalar Kalman filter: assertion macros
// Shared concurrent assertion helpers, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// Same-cycle property check.
`define SKF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define SKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Widths, reset values, register indexes, controller states and the
// command/status structs shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int DataWidth = 32;
  localparam int GainFrac  = 16;
  localparam int GainW     = GainFrac + 1;
  localparam int ExtW      = DataWidth + 1;        // sums that need one carry bit
  localparam int MulW      = ExtW + GainW;         // shared multiplier product
  localparam int CorrW     = MulW - GainFrac;      // rounded correction magnitude
  localparam int SumW      = CorrW + 2;            // signed prediction +/- correction
  localparam int DivCntW   = $clog2(GainFrac);
  localparam int CfgIdxW   = 2;

  localparam logic [GainW-1:0]     GainOne  = GainW'(1) << GainFrac;
  localparam logic [MulW-1:0]      GainHalf = MulW'(1) << (GainFrac - 1);

  localparam logic [DataWidth-1:0] InitEstRst = '0;
  localparam logic [DataWidth-1:0] InitCovRst = DataWidth'(65536);
  localparam logic [DataWidth-1:0] NoiseRst   = DataWidth'(6554);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT_EST   = 2'd0,
    CFG_INIT_COV   = 2'd1,
    CFG_PROC_NOISE = 2'd2,
    CFG_MEAS_NOISE = 2'd3
  } skf_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_SETUP,
    ST_DIV,
    ST_MUL_X,
    ST_MUL_P,
    ST_FINISH
  } skf_state_e;

  typedef struct packed {
    logic signed [DataWidth-1:0] initial_estimate;
    logic [DataWidth-1:0]        initial_covariance;
    logic [DataWidth-1:0]        proc_var;
    logic [DataWidth-1:0]        meas_var;
  } skf_cfg_t;

  typedef struct packed {
    logic load;       // capture the input item
    logic predict;    // form prediction and predicted covariance
    logic setup;      // denominator, divider seed, innovation magnitude
    logic div_step;   // one restoring division step
    logic mul_mag;    // product = |innovation| * gain
    logic mul_cov;    // corrected estimate, product = (1 - gain) * P
    logic finish;     // commit state and load the output register
  } skf_cmd_t;

  typedef struct packed {
    logic skip;       // gain settled in setup, no division needed
    logic out_busy;   // output register holds a result not yet taken
  } skf_sts_t;

  // Saturate a wide signed value to the signed data range.
  function automatic logic signed [DataWidth-1:0] sat_data(input logic signed [SumW-1:0] v);
    logic [SumW-DataWidth:0] top;
    top = v[SumW-1:DataWidth-1];
    if ((top == '0) || (top == '1)) begin
      return v[DataWidth-1:0];
    end else if (v[SumW-1]) begin
      return {1'b1, {(DataWidth-1){1'b0}}};
    end else begin
      return {1'b0, {(DataWidth-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/skf_in_if.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter input channel
// Valid/ready channel carrying one measurement and one control input.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_in_if;
  import skf_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] measurement;
  logic signed [DataWidth-1:0] ctrl_term;

  modport source (output valid, output measurement, output ctrl_term, input ready);
  modport sink   (input valid, input measurement, input ctrl_term, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skf_out_if.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter output channel
// Valid/ready channel carrying estimate, covariance and gain of one step.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_out_if;
  import skf_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] estimate;
  logic [DataWidth-1:0]        covariance;
  logic [GainW-1:0]            gain;

  modport source (output valid, output estimate, output covariance, output gain,
                  input ready);
  modport sink   (input valid, input estimate, input covariance, input gain,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skf_cfg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter configuration registers
// Four write-only registers; any write requests a state reload next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [skf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [skf_pkg::DataWidth-1:0] cfg_wdata_i,
  output skf_pkg::skf_cfg_t                  cfg_o,
  output logic                               reload_o
);
  import skf_pkg::*;

  skf_cfg_t cfg_q, cfg_d;
  logic     reload_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (skf_cfg_idx_e'(cfg_index_i))
        CFG_INIT_EST:   cfg_d.initial_estimate   = cfg_wdata_i;
        CFG_INIT_COV:   cfg_d.initial_covariance = cfg_wdata_i;
        CFG_PROC_NOISE: cfg_d.proc_var           = cfg_wdata_i;
        CFG_MEAS_NOISE: cfg_d.meas_var           = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_estimate   <= InitEstRst;
      cfg_q.initial_covariance <= InitCovRst;
      cfg_q.proc_var           <= NoiseRst;
      cfg_q.meas_var           <= NoiseRst;
      reload_q                 <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      reload_q <= cfg_we_i;
    end
  end

  assign cfg_o    = cfg_q;
  assign reload_o = reload_q;

endmodule

`default_nettype wire

FILE: hw/rtl/skf_ctrl.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter controller
// Sequences predict, gain division, correction multiplies and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire skf_pkg::skf_sts_t sts_i,
  output skf_pkg::skf_cmd_t      cmd_o
);
  import skf_pkg::*;

  skf_state_e         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd_o.predict = 1'b1;
        state_d       = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = '0;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.skip) begin
          state_d = ST_MUL_X;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == DivCntW'(GainFrac - 1)) begin
            state_d = ST_MUL_X;
          end
        end
      end
      ST_MUL_X: begin
        cmd_o.mul_mag = 1'b1;
        state_d       = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.mul_cov = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/skf_datapath.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter datapath
// Filter state, restoring gain divider, shared multiplier, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_core_defines.svh"

module skf_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire skf_pkg::skf_cmd_t                    cmd_i,
  output skf_pkg::skf_sts_t                         sts_o,
  input  wire skf_pkg::skf_cfg_t                    cfg_i,
  input  wire logic                                 reload_i,
  input  wire logic signed [skf_pkg::DataWidth-1:0] meas_i,
  input  wire logic signed [skf_pkg::DataWidth-1:0] ctrl_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [skf_pkg::DataWidth-1:0]      est_o,
  output logic [skf_pkg::DataWidth-1:0]             cov_o,
  output logic [skf_pkg::GainW-1:0]                 gain_o
);
  import skf_pkg::*;

  // filter state
  logic signed [DataWidth-1:0] est_q;
  logic [DataWidth-1:0]        cov_q;
  // per-item working registers
  logic signed [DataWidth-1:0] meas_q, ctrl_q, xp_q, xnew_q;
  logic [DataWidth-1:0]        pp_q;
  logic [ExtW-1:0]             den_q, rem_q, mag_q;
  logic                        neg_q, skip_q;
  logic [GainW-1:0]            k_q;
  logic [MulW-1:0]             prod_q;
  // output register
  logic                        out_valid_q;
  logic signed [DataWidth-1:0] est_out_q;
  logic [DataWidth-1:0]        cov_out_q;
  logic [GainW-1:0]            gain_out_q;

  logic signed [ExtW-1:0]      pred_sum, diff;
  logic [ExtW-1:0]             pp_sum, den_d;
  logic [ExtW:0]               rem_sh;
  logic                        rem_ge;
  logic [ExtW-1:0]             mul_a;
  logic [GainW-1:0]            mul_b;
  logic [MulW-1:0]             mul_p, prod_rnd;
  logic [CorrW-1:0]            corr;
  logic signed [SumW-1:0]      xp_ext, x_sum;
  logic [DataWidth-1:0]        newp;

  // predict: saturating x + u and P + Q
  assign pred_sum = ExtW'(est_q) + ExtW'(ctrl_q);
  assign pp_sum   = {1'b0, cov_q} + {1'b0, cfg_i.proc_var};

  // setup: P + R held one bit wider, innovation as sign and magnitude
  assign den_d = {1'b0, pp_q} + {1'b0, cfg_i.meas_var};
  assign diff  = ExtW'(meas_q) - ExtW'(xp_q);

  // restoring division step
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  // shared multiplier: |innovation| * K, then (1 - K) * P
  assign mul_a = cmd_i.mul_mag ? mag_q : {1'b0, pp_q};
  assign mul_b = cmd_i.mul_mag ? k_q : (GainOne - k_q);
  assign mul_p = MulW'(mul_a) * MulW'(mul_b);

  // correction rounds half away from zero (applied to the magnitude)
  assign prod_rnd = prod_q + GainHalf;
  assign corr     = prod_rnd[MulW-1:GainFrac];
  assign xp_ext   = SumW'(xp_q);
  assign x_sum    = neg_q ? (xp_ext - $signed({2'b00, corr}))
                          : (xp_ext + $signed({2'b00, corr}));

  // covariance update truncates
  assign newp = prod_q[GainFrac +: DataWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q       <= InitEstRst;
      cov_q       <= InitCovRst;
      k_q         <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (reload_i) begin
        est_q <= cfg_i.initial_estimate;
        cov_q <= cfg_i.initial_covariance;
      end else if (cmd_i.finish) begin
        est_q <= xnew_q;
        cov_q <= newp;
      end

      if (cmd_i.setup) begin
        if (den_d == '0) begin
          k_q    <= '0;
          skip_q <= 1'b1;
        end else if ({1'b0, pp_q} >= den_d) begin
          k_q    <= GainOne;
          skip_q <= 1'b1;
        end else begin
          k_q    <= '0;
          skip_q <= 1'b0;
        end
      end else if (cmd_i.div_step) begin
        k_q <= {k_q[GainW-2:0], rem_ge};
      end

      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      meas_q <= meas_i;
      ctrl_q <= ctrl_i;
    end
    if (cmd_i.predict) begin
      xp_q <= sat_data(SumW'(pred_sum));
      pp_q <= pp_sum[DataWidth] ? '1 : pp_sum[DataWidth-1:0];
    end
    if (cmd_i.setup) begin
      den_q <= den_d;
      rem_q <= {1'b0, pp_q};
      neg_q <= diff[ExtW-1];
      mag_q <= diff[ExtW-1] ? ExtW'(-diff) : ExtW'(diff);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? ExtW'(rem_sh - {1'b0, den_q}) : rem_sh[ExtW-1:0];
    end
    if (cmd_i.mul_mag || cmd_i.mul_cov) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul_cov) begin
      xnew_q <= sat_data(x_sum);
    end
    if (cmd_i.finish) begin
      est_out_q  <= xnew_q;
      cov_out_q  <= newp;
      gain_out_q <= k_q;
    end
  end

  assign sts_o.skip     = skip_q;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign est_o       = est_out_q;
  assign cov_o       = cov_out_q;
  assign gain_o      = gain_out_q;

  `SKF_ASSERT(a_gain_le_one, clk_i, rst_ni, k_q <= GainOne, "gain above 1.0")
  `SKF_ASSERT(a_div_rem, clk_i, rst_ni, !cmd_i.div_step || (rem_q < den_q), "div remainder")
  `SKF_ASSERT_NEXT(a_cov_le, clk_i, rst_ni, cmd_i.finish, cov_q <= $past(pp_q), "covariance grew")

endmodule

`default_nettype wire

FILE: hw/rtl/scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter core
// One-dimensional Q16.16 Kalman filter: predict, gain division, correction.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : valid/ready channel; one transfer = measurement + control input.
//   out_o : valid/ready channel; one transfer = estimate, covariance, gain.
//   cfg_* : write-only port for initial estimate, initial covariance,
//           process noise and measurement noise. Any write reloads the
//           filter state from the initial registers through a registered
//           reload request; write only while no item is in flight.
// Sequence: load, predict, setup, restoring gain divider (one bit per
//   cycle), correction multiplies, commit. The divider is skipped when
//   the gain settles in setup (zero denominator or zero sensor noise).
// Flow: one item is worked at a time and the input is ready whenever
//   the sequencer is idle.
// Stall: the result sits in an output register. A new item is taken while
//   it waits; that item's commit waits until the previous result is gone.
// Reset: registers return to their defaults and the state takes the same
//   values (estimate 0, covariance 1.0); both channels come up idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [skf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [skf_pkg::DataWidth-1:0] cfg_wdata_i,
  skf_in_if.sink                             in_i,
  skf_out_if.source                          out_o
);
  import skf_pkg::*;

  skf_cfg_t cfg;
  logic     reload;
  skf_cmd_t cmd;
  skf_sts_t sts;

  // configuration registers and reload request
  skf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .reload_o    (reload)
  );

  // sequencer: owns the input handshake
  skf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, filter state and output register
  skf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg),
    .reload_i    (reload),
    .meas_i      (in_i.measurement),
    .ctrl_i      (in_i.ctrl_term),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .est_o       (out_o.estimate),
    .cov_o       (out_o.covariance),
    .gain_o      (out_o.gain)
  );

endmodule

`default_nettype wire
